### rtl/qti_pkg.sv
`timescale 1ns / 1ps

package qti_pkg;

	localparam int DATA_W = 32;
	localparam int NUM_W  = 112;
	localparam int DEN_W  = 64;
	localparam int SUM_W  = 128;
	localparam int CNT_REG_W = 5;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REGION_INSIDE = 2'd0;
	localparam logic [1:0] REGION_BELOW  = 2'd1;
	localparam logic [1:0] REGION_ABOVE  = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         entry_index;
		logic signed [31:0] knot_value;
		logic signed [31:0] table_value;
		logic signed [31:0] query_x;
	} qti_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               exact_hit;
		logic [1:0]         region;
		logic               saturated;
	} qti_result_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} qti_div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_CHK_LAST,
		ST_SEARCH,
		ST_SCHK,
		ST_PT_RD,
		ST_PT_CAP,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_DEN,
		ST_DIV,
		ST_FINAL
	} qti_state_t;

endpackage

### rtl/qti_ram.sv
`timescale 1ns / 1ps

module qti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/qti_mul.sv
`timescale 1ns / 1ps

module qti_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] p
);

	// registered 33x33 unsigned product
	always_ff @(posedge clk) begin
		p <= 66'(a) * 66'(b);
	end

endmodule

### rtl/qti_div.sv
`timescale 1ns / 1ps

module qti_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qti_pkg::qti_div_req_t    req,
	output logic                     done,
	output logic [qti_pkg::NUM_W-1:0] quot
);

	import qti_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   rem2;
	logic             ge;

	// one restoring step per cycle
	assign rem2 = {rem_q, nq_q[NUM_W-1]};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold the shifting dividend/quotient and the partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (run_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

### rtl/quadratic_table_interpolator.sv
`timescale 1ns / 1ps

// Table interpolator: load beats (opcode 0) write one knot/value pair and
// give no result. A query beat (opcode 1) checks the edge knots, and when x
// lies between them binary-searches the knots in use; it then either returns
// the value of a knot that the search hits exactly or runs three-point
// Lagrange interpolation through three neighboring knots. busy stays high for
// the whole query: the edge checks, the search steps, the fetch of the three
// points, then per Lagrange term the multiplier steps and the bit-serial
// divider, and a final rounding step. The three terms share one multiplier
// and one divider. The result appears for exactly one cycle with done high
// and cannot be stalled.
module quadratic_table_interpolator #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  qti_pkg::qti_item_t        item,
	input  logic                      cfg_we,
	input  logic [4:0]                cfg_wdata,
	output logic                      done,
	output qti_pkg::qti_result_t      result
);

	import qti_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	qti_state_t state_q, state_d;

	logic [CNT_REG_W-1:0] table_count_q;
	logic [CW-1:0]        n_q;
	logic signed [31:0]   x_q;
	logic [IW-1:0]        lo_q, hi_q, mid_q, k1_q;
	logic [1:0]           pt_q, term_q;
	logic [1:0]           region_q;
	logic signed [31:0]   b_q [3];
	logic signed [31:0]   f_q [3];
	logic [31:0]          p1hi_q;
	logic [64:0]          plo_q;
	logic [96:0]          num_q;
	logic [SUM_W-1:0]     sum_q;

	logic                 accept;
	logic [IW-1:0]        raddr, mid, nm1, nm3;
	logic [31:0]          rk, rv;
	logic [31:0]          idx_ext;
	logic [31:0]          tc_ext;
	logic                 we;

	logic signed [31:0]   bi, bj, bk, fi;
	logic signed [32:0]   xj, xk, ij, ik;
	logic [32:0]          fi_m, xj_m, xk_m, ij_m, ik_m;
	logic                 neg;

	logic [32:0]          mul_a, mul_b;
	logic [65:0]          mul_p;
	qti_div_req_t         div_req;
	logic                 div_done;
	logic [NUM_W-1:0]     div_q;
	logic [SUM_W-1:0]     term_val;

	logic                 fin;
	qti_result_t          fin_res;
	logic [SUM_W-1:0]     rsum, rsh;

	assign accept  = start && !busy;
	assign busy    = state_q != ST_IDLE;
	assign idx_ext = 32'(item.entry_index);
	assign we      = accept && item.opcode == OP_LOAD && idx_ext < 32'(TABLE_DEPTH);
	assign tc_ext  = 32'(table_count_q);
	assign nm1     = IW'(n_q - CW'(1));
	assign nm3     = IW'(n_q - CW'(3));
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	qti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_knot (
		.clk(clk), .we(we), .waddr(idx_ext[IW-1:0]), .wdata(item.knot_value),
		.raddr(raddr), .rdata(rk)
	);

	qti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_value (
		.clk(clk), .we(we), .waddr(idx_ext[IW-1:0]), .wdata(item.table_value),
		.raddr(raddr), .rdata(rv)
	);

	qti_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	qti_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done),
		.quot(div_q));

	// pick the knots of the current Lagrange term
	always_comb begin
		case (term_q)
			2'd0: begin
				bi = b_q[0]; bj = b_q[1]; bk = b_q[2]; fi = f_q[0];
			end
			2'd1: begin
				bi = b_q[1]; bj = b_q[0]; bk = b_q[2]; fi = f_q[1];
			end
			default: begin
				bi = b_q[2]; bj = b_q[0]; bk = b_q[1]; fi = f_q[2];
			end
		endcase
	end

	// term differences and magnitudes
	always_comb begin
		xj   = 33'(x_q) - 33'(bj);
		xk   = 33'(x_q) - 33'(bk);
		ij   = 33'(bi) - 33'(bj);
		ik   = 33'(bi) - 33'(bk);
		fi_m = fi[31] ? 33'(-33'(fi)) : 33'(fi);
		xj_m = xj[32] ? 33'(-xj) : 33'(xj);
		xk_m = xk[32] ? 33'(-xk) : 33'(xk);
		ij_m = ij[32] ? 33'(-ij) : 33'(ij);
		ik_m = ik[32] ? 33'(-ik) : 33'(ik);
		neg  = fi[31] ^ xj[32] ^ xk[32] ^ ij[32] ^ ik[32];
	end

	assign term_val = neg ? SUM_W'(-SUM_W'(div_q)) : SUM_W'(div_q);

	// round half up, drop the extra fraction bits
	assign rsum = sum_q + SUM_W'(32'h8000);
	assign rsh  = SUM_W'($signed(rsum) >>> 16);

	// sequence one query
	always_comb begin
		state_d     = state_q;
		raddr       = '0;
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		fin         = 1'b0;
		fin_res     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.opcode == OP_QUERY) begin
					state_d = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				raddr   = '0;
				state_d = ST_CHK_FIRST;
			end
			ST_CHK_FIRST: begin
				raddr = nm1;
				if (x_q < $signed(rk)) begin
					state_d = ST_PT_RD;
				end else begin
					state_d = ST_CHK_LAST;
				end
			end
			ST_CHK_LAST: begin
				if (x_q > $signed(rk)) begin
					state_d = ST_PT_RD;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				raddr = mid;
				if (hi_q - lo_q > IW'(1)) begin
					state_d = ST_SCHK;
				end else begin
					state_d = ST_PT_RD;
				end
			end
			ST_SCHK: begin
				if ($signed(rk) == x_q) begin
					fin                  = 1'b1;
					fin_res.result_value = rv;
					fin_res.exact_hit    = 1'b1;
					fin_res.region       = REGION_INSIDE;
					state_d              = ST_IDLE;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_PT_RD: begin
				raddr   = k1_q + IW'(pt_q);
				state_d = ST_PT_CAP;
			end
			ST_PT_CAP: begin
				state_d = (pt_q == 2'd2) ? ST_MUL1 : ST_PT_RD;
			end
			ST_MUL1: begin
				mul_a = fi_m;
				mul_b = xj_m;
				if (ij == '0 || ik == '0) begin
					fin                  = 1'b1;
					fin_res.result_value = 32'sh7FFFFFFF;
					fin_res.region       = region_q;
					fin_res.saturated    = 1'b1;
					state_d              = ST_IDLE;
				end else begin
					state_d = ST_MUL2;
				end
			end
			ST_MUL2: begin
				mul_a   = {1'b0, mul_p[31:0]};
				mul_b   = xk_m;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				mul_a   = {1'b0, p1hi_q};
				mul_b   = xk_m;
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				mul_a   = ij_m;
				mul_b   = ik_m;
				state_d = ST_DEN;
			end
			ST_DEN: begin
				div_req.start = 1'b1;
				div_req.num   = {num_q[95:0], 16'h0000};
				div_req.den   = mul_p[63:0];
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (term_q == 2'd2) ? ST_FINAL : ST_MUL1;
				end
			end
			ST_FINAL: begin
				fin            = 1'b1;
				fin_res.region = region_q;
				if (rsh[SUM_W-1:31] == '0 || rsh[SUM_W-1:31] == '1) begin
					fin_res.result_value = rsh[31:0];
				end else begin
					fin_res.result_value = rsum[SUM_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
					fin_res.saturated    = 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state, config and the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_count_q <= CNT_REG_W'(16);
			done          <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			if (cfg_we) begin
				table_count_q <= cfg_wdata;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin) begin
			result <= fin_res;
		end
		case (state_q)
			ST_IDLE: begin
				x_q    <= item.query_x;
				pt_q   <= 2'd0;
				term_q <= 2'd0;
				sum_q  <= '0;
				if (tc_ext < 32'd3) begin
					n_q <= CW'(3);
				end else if (tc_ext > 32'(TABLE_DEPTH)) begin
					n_q <= CW'(TABLE_DEPTH);
				end else begin
					n_q <= CW'(tc_ext);
				end
			end
			ST_CHK_FIRST: begin
				region_q <= REGION_BELOW;
				k1_q     <= '0;
			end
			ST_CHK_LAST: begin
				if (x_q > $signed(rk)) begin
					region_q <= REGION_ABOVE;
					k1_q     <= nm3;
				end else begin
					region_q <= REGION_INSIDE;
					lo_q     <= '0;
					hi_q     <= nm1;
				end
			end
			ST_SEARCH: begin
				mid_q <= mid;
				k1_q  <= (hi_q == nm1) ? nm3 : lo_q;
			end
			ST_SCHK: begin
				if ($signed(rk) < x_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_PT_CAP: begin
				b_q[pt_q] <= rk;
				f_q[pt_q] <= rv;
				pt_q      <= pt_q + 2'd1;
			end
			ST_MUL2: p1hi_q <= mul_p[63:32];
			ST_MUL3: plo_q  <= mul_p[64:0];
			ST_MUL4: num_q  <= 97'(plo_q) + {mul_p[64:0], 32'h0};
			ST_DIV: begin
				if (div_done) begin
					sum_q  <= sum_q + term_val;
					term_q <= term_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule
